FILE: rtl/core/lbg_pkg.sv
// Shared types and constants for the LED bar graph renderer.
`default_nettype none

package lbg_pkg;

  localparam int VALUE_W   = 16;
  localparam int SWIDTH_W  = 6;
  localparam int CENTER_W  = 5;
  localparam int PATTERN_W = 32;

  // Full-scale counts and rounding offsets of the three scales.
  localparam logic [16:0] LEFT_FULL = 17'd65535;
  localparam logic [16:0] LEFT_HALF = 17'd32767;
  localparam logic [16:0] POS_FULL  = 17'd32767;
  localparam logic [16:0] POS_HALF  = 17'd16383;
  localparam logic [16:0] NEG_HALF  = 17'd16384;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [SWIDTH_W-1:0] strip_width;
    logic [CENTER_W-1:0] center_index;
    logic                center_scale;
    logic                point_mode;
  } in_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/lbg_in_if.sv
// Input channel of the LED bar graph renderer: valid/ready plus strip fields.
`default_nettype none

interface lbg_in_if
  import lbg_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [SWIDTH_W-1:0] strip_width;
  logic [CENTER_W-1:0] center_index;
  logic                center_scale;
  logic                point_mode;

  modport source (
    output valid, value, strip_width, center_index, center_scale, point_mode,
    input  ready
  );

  modport sink (
    input  valid, value, strip_width, center_index, center_scale, point_mode,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/lbg_out_if.sv
// Result channel of the LED bar graph renderer: valid/ready plus LED pattern.
`default_nettype none

interface lbg_out_if
  import lbg_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [PATTERN_W-1:0] pattern;

  modport source (
    output valid, pattern,
    input  ready
  );

  modport sink (
    input  valid, pattern,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/led_bar_graph_renderer_core.sv
// LED bar graph renderer top level: input register, pattern logic, result register.
// Path: an accepted item is held in the input register, then its pattern in the result register.
// Throughput: one item per cycle unless a waiting result stalls; the single scale multiply and
// constant-divide correction sit between the two registers.
// A waiting result stalls the input once the input register also holds an item.
// Reset (rst_n low, synchronous) empties both stages; payload regs are not reset.
`default_nettype none

module led_bar_graph_renderer_core
  import lbg_pkg::*;
#(
  parameter int MAX_WIDTH = 32
) (
  input  wire       clk,
  input  wire       rst_n,
  lbg_in_if.sink    in_ch,
  lbg_out_if.source out_ch
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int KW  = (WW > CENTER_W) ? WW : CENTER_W;
  localparam int PRW = VALUE_W + WW + 1;

  logic                 s1_valid_r;
  in_item_t             s1_r;
  logic                 out_valid_r;
  logic [PATTERN_W-1:0] out_pattern_r;
  logic [PATTERN_W-1:0] pattern_nxt;

  logic                 s1_ready;
  logic                 s2_free;

  logic [WW-1:0]        w;
  logic [WW-1:0]        c;
  logic                 neg;
  logic [VALUE_W-1:0]   num;
  logic [WW-1:0]        span;
  logic [16:0]          half;
  logic [PRW-1:0]       x;
  logic [WW:0]          q_left;
  logic [16:0]          r_left;
  logic [WW+1:0]        q_pos;
  logic [16:0]          r_pos;
  logic [WW-1:0]        n;
  logic [WW-1:0]        lo;
  logic [WW-1:0]        hi;
  logic                 en;

  assign s2_free     = !out_valid_r || out_ch.ready;
  assign s1_ready    = !s1_valid_r || s2_free;
  assign in_ch.ready = s1_ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pattern = out_pattern_r;

  // Clamp width and center, pick the scale, scale the value to a count, then build the pattern.
  always_comb begin
    if ({1'b0, s1_r.strip_width} > 7'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(s1_r.strip_width);
    end

    if (KW'(s1_r.center_index) < KW'(w)) begin
      c = WW'(s1_r.center_index);
    end else begin
      c = w - WW'(1);
    end

    neg = s1_r.center_scale && s1_r.value[VALUE_W-1];

    if (!s1_r.center_scale) begin
      num  = s1_r.value;
      span = w;
      half = LEFT_HALF;
    end else if (!neg) begin
      num  = s1_r.value;
      span = w - WW'(1) - c;
      half = POS_HALF;
    end else begin
      num  = VALUE_W'(~s1_r.value + VALUE_W'(1));
      span = c;
      half = NEG_HALF;
    end

    x = PRW'(num) * PRW'(span) + PRW'(half);

    // x / 65535: quotient estimate from the top bits, one correction step.
    q_left = x[PRW-1:16];
    r_left = {1'b0, x[15:0]} + 17'(q_left);
    // x / 32767: same scheme with a 15-bit split.
    q_pos  = x[PRW-1:15];
    r_pos  = {2'b0, x[14:0]} + 17'(q_pos);

    if (!s1_r.center_scale) begin
      n = (r_left >= LEFT_FULL) ? WW'(q_left + (WW+1)'(1)) : WW'(q_left);
    end else if (!neg) begin
      n = (r_pos >= POS_FULL) ? WW'(q_pos + (WW+2)'(1)) : WW'(q_pos);
    end else begin
      n = WW'(x[PRW-1:15]);
    end

    en = 1'b1;
    lo = '0;
    hi = '0;
    if (w == '0) begin
      en = 1'b0;
    end else if (w == WW'(1)) begin
      en = (s1_r.value != '0);
    end else if (!s1_r.center_scale) begin
      en = (n != '0);
      hi = n - WW'(1);
      lo = s1_r.point_mode ? (n - WW'(1)) : '0;
    end else if (!neg) begin
      hi = c + n;
      lo = s1_r.point_mode ? (c + n) : c;
    end else begin
      lo = c - n;
      hi = s1_r.point_mode ? (c - n) : c;
    end

    for (int i = 0; i < PATTERN_W; i++) begin
      pattern_nxt[i] = en && (KW'(i) >= KW'(lo)) && (KW'(i) <= KW'(hi));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_ready) begin
      s1_r.value        <= in_ch.value;
      s1_r.strip_width  <= in_ch.strip_width;
      s1_r.center_index <= in_ch.center_index;
      s1_r.center_scale <= in_ch.center_scale;
      s1_r.point_mode   <= in_ch.point_mode;
    end
    if (s1_valid_r && s2_free) begin
      out_pattern_r <= pattern_nxt;
    end
  end

endmodule

`default_nettype wire
